### rtl/vertex_delta_bitpack_decoder_top_assert.svh
// Assertion macros for the vertex delta bit-pack decoder checker.
// Used by the checker module only; needs a clk and rst_n in scope.
`ifndef VERTEX_DELTA_BITPACK_DECODER_TOP_ASSERT_SVH
`define VERTEX_DELTA_BITPACK_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VDBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdbd assertion failed");

`endif

### rtl/vdbd_pkg.sv
// Package for the vertex delta bit-pack decoder: widths, codes, types, helpers.
// No dependencies; used by the extraction unit, the top level and the checker.
`default_nettype none

package vdbd_pkg;

    localparam int unsigned MAX_DIMS     = 3;
    localparam int unsigned MAX_VERTICES = 256;

    localparam int WORD_W   = 32;
    localparam int BUF_W    = 64;
    localparam int HELD_W   = 7;
    localparam int PREC_W   = 6;
    localparam int SHIFT_W  = 5;
    localparam int VCOUNT_W = 9;
    localparam int DIMS_W   = 2;
    localparam int VIDX_W   = 8;
    localparam int HDR_PREC_LSB = 16;

    typedef enum logic
    {
        CTL_IDLE,
        CTL_EXTRACT
    } ctl_state_t;

    typedef enum logic [1:0]
    {
        STAGE_HEADER = 2'd0,
        STAGE_BASES  = 2'd1,
        STAGE_DELTAS = 2'd2
    } stage_t;

    typedef enum logic
    {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_DIMS         = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic [BUF_W-1:0]   buffer;
        logic [HELD_W-1:0]  held;
        logic [PREC_W-1:0]  prec;
        logic [SHIFT_W-1:0] shift;
        logic [WORD_W-1:0]  base;
    } extract_op_t;

    typedef struct packed
    {
        logic               avail;
        logic [WORD_W-1:0]  coord;
        logic [BUF_W-1:0]   rest;
        logic [HELD_W-1:0]  rest_held;
    } extract_res_t;

    function automatic logic [DIMS_W-1:0] eff_dims(input logic [DIMS_W-1:0] d);
        logic [DIMS_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIMS_W'(1);
        end
        else if (32'(d) > MAX_DIMS)
        begin
            r = DIMS_W'(MAX_DIMS);
        end
        return r;
    endfunction

    function automatic logic [VCOUNT_W-1:0] eff_count(input logic [VCOUNT_W-1:0] c);
        logic [VCOUNT_W-1:0] r;
        r = c;
        if (c == '0)
        begin
            r = VCOUNT_W'(1);
        end
        else if (32'(c) > MAX_VERTICES)
        begin
            r = VCOUNT_W'(MAX_VERTICES);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/vdbd_extract_unit.sv
// Shared extraction unit: takes one delta off the bit buffer and restores a coordinate.
// Depends on vdbd_pkg for the operand and result types.
`default_nettype none

module vdbd_extract_unit
(
    input  wire vdbd_pkg::extract_op_t  op,
    output vdbd_pkg::extract_res_t      res
);

    logic [vdbd_pkg::WORD_W:0]   mask_wide;
    logic [vdbd_pkg::WORD_W-1:0] mask;
    logic [vdbd_pkg::WORD_W-1:0] delta;

    assign mask_wide = ((vdbd_pkg::WORD_W+1)'(1) << op.prec) - (vdbd_pkg::WORD_W+1)'(1);
    assign mask      = mask_wide[vdbd_pkg::WORD_W-1:0];
    assign delta     = op.buffer[vdbd_pkg::WORD_W-1:0] & mask;

    assign res.avail     = op.held >= {1'b0, op.prec};
    assign res.coord     = op.base + (delta << op.shift);
    assign res.rest      = op.buffer >> op.prec;
    assign res.rest_held = op.held - {1'b0, op.prec};

endmodule

`default_nettype wire

### rtl/vertex_delta_bitpack_decoder_top.sv
// Header and base words are taken while the controller is idle. A delta word is added to
// the bit buffer, then the extract state registers one coordinate per cycle into the output
// register while the output slot is free. The input stays stalled until the single shared
// extraction unit finds the buffer short; a word that ends the cluster returns to idle
// without that check, and stalls on the output keep the input stalled longer.
// Reset (rst_n, asynchronous, active low) returns to the header stage with empty buffer.
`default_nettype none

module vertex_delta_bitpack_decoder_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [vdbd_pkg::WORD_W-1:0]     stream_word,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [vdbd_pkg::WORD_W-1:0]          coord_value,
    output logic [vdbd_pkg::DIMS_W-1:0]          dim_index,
    output logic [vdbd_pkg::VIDX_W-1:0]          vertex_index,
    output logic                                 cluster_last,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [vdbd_pkg::VCOUNT_W-1:0]   cfg_wdata
);

    localparam int ND = vdbd_pkg::MAX_DIMS;

    vdbd_pkg::ctl_state_t ctl_reg, ctl_next;
    vdbd_pkg::stage_t     stage_reg, stage_next;

    logic [vdbd_pkg::VCOUNT_W-1:0] vcount_cfg_reg;
    logic [vdbd_pkg::DIMS_W-1:0]   dims_cfg_reg;

    logic [vdbd_pkg::DIMS_W-1:0]   base_idx_reg, base_idx_next;
    logic [vdbd_pkg::WORD_W-1:0]   base_reg [ND];
    logic [vdbd_pkg::WORD_W-1:0]   base_next [ND];
    logic [vdbd_pkg::SHIFT_W-1:0]  shift_reg [ND];
    logic [vdbd_pkg::SHIFT_W-1:0]  shift_next [ND];
    logic [vdbd_pkg::PREC_W-1:0]   prec_reg [ND];
    logic [vdbd_pkg::PREC_W-1:0]   prec_next [ND];
    logic [vdbd_pkg::BUF_W-1:0]    buf_reg, buf_next;
    logic [vdbd_pkg::HELD_W-1:0]   held_reg, held_next;
    logic [vdbd_pkg::DIMS_W-1:0]   cdim_reg, cdim_next;
    logic [vdbd_pkg::VCOUNT_W-1:0] vcnt_reg, vcnt_next;

    logic                          out_valid_reg, out_valid_next;
    logic [vdbd_pkg::WORD_W-1:0]   coord_reg, coord_next;
    logic [vdbd_pkg::DIMS_W-1:0]   odim_reg, odim_next;
    logic [vdbd_pkg::VIDX_W-1:0]   ovtx_reg, ovtx_next;
    logic                          olast_reg, olast_next;

    logic [vdbd_pkg::DIMS_W-1:0]   nd;
    logic [vdbd_pkg::VCOUNT_W-1:0] nv;
    logic [vdbd_pkg::DIMS_W:0]     base_idx_inc;
    logic                          slot_free;
    logic                          last_dim;
    logic                          last_coord;

    vdbd_pkg::extract_op_t  unit_op;
    vdbd_pkg::extract_res_t unit_res;

    vdbd_extract_unit u_unit
    (
        .op  (unit_op),
        .res (unit_res)
    );

    assign nd           = vdbd_pkg::eff_dims(dims_cfg_reg);
    assign nv           = vdbd_pkg::eff_count(vcount_cfg_reg);
    assign base_idx_inc = {1'b0, base_idx_reg} + (vdbd_pkg::DIMS_W+1)'(1);
    assign slot_free    = !out_valid_reg || !out_stall;
    assign last_dim     = ({1'b0, cdim_reg} + (vdbd_pkg::DIMS_W+1)'(1)) >= {1'b0, nd};
    assign last_coord   = last_dim
                          && (({1'b0, vcnt_reg} + (vdbd_pkg::VCOUNT_W+1)'(1)) >= {1'b0, nv});

    assign unit_op.buffer = buf_reg;
    assign unit_op.held   = held_reg;
    assign unit_op.prec   = prec_reg[cdim_reg];
    assign unit_op.shift  = shift_reg[cdim_reg];
    assign unit_op.base   = base_reg[cdim_reg];

    assign in_stall     = (ctl_reg != vdbd_pkg::CTL_IDLE);
    assign out_valid    = out_valid_reg;
    assign coord_value  = coord_reg;
    assign dim_index    = odim_reg;
    assign vertex_index = ovtx_reg;
    assign cluster_last = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_cfg_reg <= vdbd_pkg::VCOUNT_W'(1);
            dims_cfg_reg   <= vdbd_pkg::DIMS_W'(3);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vdbd_pkg::CFG_VERTEX_COUNT: vcount_cfg_reg <= cfg_wdata;
                vdbd_pkg::CFG_DIMS:         dims_cfg_reg   <= cfg_wdata[vdbd_pkg::DIMS_W-1:0];
                default:                    vcount_cfg_reg <= vcount_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= vdbd_pkg::CTL_IDLE;
            stage_reg     <= vdbd_pkg::STAGE_HEADER;
            base_idx_reg  <= '0;
            buf_reg       <= '0;
            held_reg      <= '0;
            cdim_reg      <= '0;
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < ND; d++)
            begin
                base_reg[d]  <= '0;
                shift_reg[d] <= '0;
                prec_reg[d]  <= vdbd_pkg::PREC_W'(1);
            end
        end
        else
        begin
            ctl_reg       <= ctl_next;
            stage_reg     <= stage_next;
            base_idx_reg  <= base_idx_next;
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            cdim_reg      <= cdim_next;
            vcnt_reg      <= vcnt_next;
            out_valid_reg <= out_valid_next;
            for (int d = 0; d < ND; d++)
            begin
                base_reg[d]  <= base_next[d];
                shift_reg[d] <= shift_next[d];
                prec_reg[d]  <= prec_next[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
        odim_reg  <= odim_next;
        ovtx_reg  <= ovtx_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        ctl_next       = ctl_reg;
        stage_next     = stage_reg;
        base_idx_next  = base_idx_reg;
        buf_next       = buf_reg;
        held_next      = held_reg;
        cdim_next      = cdim_reg;
        vcnt_next      = vcnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        coord_next     = coord_reg;
        odim_next      = odim_reg;
        ovtx_next      = ovtx_reg;
        olast_next     = olast_reg;
        for (int d = 0; d < ND; d++)
        begin
            base_next[d]  = base_reg[d];
            shift_next[d] = shift_reg[d];
            prec_next[d]  = prec_reg[d];
        end

        case (ctl_reg)
            vdbd_pkg::CTL_IDLE:
            begin
                if (in_valid)
                begin
                    case (stage_reg)
                        vdbd_pkg::STAGE_BASES:
                        begin
                            base_next[base_idx_reg] = stream_word;
                            base_idx_next = base_idx_inc[vdbd_pkg::DIMS_W-1:0];
                            if (base_idx_next >= nd)
                            begin
                                stage_next = vdbd_pkg::STAGE_DELTAS;
                                buf_next   = '0;
                                held_next  = '0;
                                cdim_next  = '0;
                                vcnt_next  = '0;
                            end
                        end
                        vdbd_pkg::STAGE_DELTAS:
                        begin
                            buf_next  = buf_reg
                                        | ({{(vdbd_pkg::BUF_W-vdbd_pkg::WORD_W){1'b0}}, stream_word}
                                           << held_reg[4:0]);
                            held_next = held_reg + vdbd_pkg::HELD_W'(vdbd_pkg::WORD_W);
                            ctl_next  = vdbd_pkg::CTL_EXTRACT;
                        end
                        default:
                        begin
                            for (int d = 0; d < ND; d++)
                            begin
                                shift_next[d] = stream_word[5*d +: vdbd_pkg::SHIFT_W];
                                prec_next[d]  = {1'b0,
                                    stream_word[vdbd_pkg::HDR_PREC_LSB + 5*d +: vdbd_pkg::SHIFT_W]}
                                    + vdbd_pkg::PREC_W'(1);
                            end
                            stage_next    = vdbd_pkg::STAGE_BASES;
                            base_idx_next = '0;
                        end
                    endcase
                end
            end
            vdbd_pkg::CTL_EXTRACT:
            begin
                if (!unit_res.avail)
                begin
                    ctl_next = vdbd_pkg::CTL_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    coord_next     = unit_res.coord;
                    odim_next      = cdim_reg;
                    ovtx_next      = vcnt_reg[vdbd_pkg::VIDX_W-1:0];
                    olast_next     = last_coord;
                    buf_next       = unit_res.rest;
                    held_next      = unit_res.rest_held;
                    if (last_dim)
                    begin
                        cdim_next = '0;
                        vcnt_next = vcnt_reg + vdbd_pkg::VCOUNT_W'(1);
                    end
                    else
                    begin
                        cdim_next = cdim_reg + vdbd_pkg::DIMS_W'(1);
                    end
                    if (last_coord)
                    begin
                        stage_next = vdbd_pkg::STAGE_HEADER;
                        buf_next   = '0;
                        held_next  = '0;
                        cdim_next  = '0;
                        vcnt_next  = '0;
                        ctl_next   = vdbd_pkg::CTL_IDLE;
                    end
                end
            end
            default:
            begin
                ctl_next = vdbd_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/vdbd_checker.sv
// Port-level checker for the vertex delta bit-pack decoder, bound to the top level.
// Depends on vdbd_pkg and the assertion macros in vertex_delta_bitpack_decoder_top_assert.svh.
`default_nettype none

`include "vertex_delta_bitpack_decoder_top_assert.svh"

module vdbd_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [vdbd_pkg::WORD_W-1:0]     stream_word,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [vdbd_pkg::WORD_W-1:0]     coord_value,
    input wire logic [vdbd_pkg::DIMS_W-1:0]     dim_index,
    input wire logic [vdbd_pkg::VIDX_W-1:0]     vertex_index,
    input wire logic                            cluster_last,
    input wire logic                            cfg_wr_en,
    input wire logic                            cfg_index,
    input wire logic [vdbd_pkg::VCOUNT_W-1:0]   cfg_wdata
);

    // A stalled output word keeps its coordinate.
    `VDBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(coord_value))

    // Only three dimensions exist, so the top dimension code never appears.
    `VDBD_ASSERT_SAME(a_dim_range, out_valid, dim_index != 2'd3)

    // A stalled output word also keeps its dimension and vertex.
    `VDBD_ASSERT_NEXT(a_tag_hold, out_valid && out_stall, $stable({dim_index, vertex_index}))

endmodule

bind vertex_delta_bitpack_decoder_top vdbd_checker u_vdbd_checker (.*);

`default_nettype wire
